// ===== rtl/sitda_pkg.sv =====
`default_nettype none

package sitda_pkg;

  localparam int VALUE_W   = 32;
  localparam int CHAR_W    = 8;
  localparam int DIGIT_W   = 4;
  // Ten decimal digits cover every 32-bit magnitude.
  localparam int NUM_CELLS = 10;
  localparam int CNT_W     = $clog2(VALUE_W);
  localparam int LEFT_W    = $clog2(NUM_CELLS + 1);

  localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0]  ASCII_MINUS = 8'd45;
  localparam logic [DIGIT_W-1:0] BCD_ADJ_MIN = 4'd5;
  localparam logic [DIGIT_W-1:0] BCD_ADJ     = 4'd3;

  typedef struct packed {
    logic clear;
    logic bcd_shift;
    logic digit_shift;
  } cell_ctrl_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CONV  = 5'b00010,
    S_STRIP = 5'b00100,
    S_SIGN  = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/signed_int_to_decimal_ascii_unit.sv =====
`default_nettype none

// Channel | Direction | Ports                         | Transfer when
// --------+-----------+-------------------------------+------------------------
// in      | input     | in_value                      | in_valid && !in_stall
// out     | output    | out_character, out_last       | out_valid && !out_stall
//
// One number at a time: the controller takes the value, shifts and adjusts all 32 bits of its
// magnitude through the ten digit cells, finds the first significant digit, then makes ten digit
// shifts that either drop a leading zero or send a character, with a minus sign sent before
// the digits of a negative number.
// Synchronous active-low reset returns the controller to idle and empties the output.
// A stall on the output holds the character register and pauses the emit sequence.

module signed_int_to_decimal_ascii_unit
  import sitda_pkg::*;
(
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_stall,
  input  wire signed [VALUE_W-1:0] in_value,
  output logic                    out_valid,
  input  wire                     out_stall,
  output logic [CHAR_W-1:0]       out_character,
  output logic                    out_last
);

  state_t              state_r, state_nxt;
  logic [VALUE_W-1:0]  mag_r, mag_nxt;
  logic [CNT_W-1:0]    bitcnt_r, bitcnt_nxt;
  logic [LEFT_W-1:0]   left_r, left_nxt;
  logic                neg_r, neg_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]   out_character_r, out_character_nxt;
  logic                out_last_r, out_last_nxt;

  cell_ctrl_t          ctrl;
  logic [VALUE_W-1:0]  value_u;
  logic                slot_free;
  logic                top_zero;
  logic [DIGIT_W-1:0]  digit   [NUM_CELLS];
  logic                bit_out [NUM_CELLS];

  assign value_u   = in_value;
  assign slot_free = !out_valid_r || !out_stall;
  assign top_zero  = (digit[NUM_CELLS-1] == '0);
  assign in_stall  = (state_r != S_IDLE);

  // Cell 0 holds the least significant digit; data move towards the top cell.
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    if (i == 0) begin : g_first
      sitda_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .bit_in   (mag_r[VALUE_W-1]),
        .digit_in ({DIGIT_W{1'b0}}),
        .bit_out  (bit_out[i]),
        .digit    (digit[i])
      );
    end else begin : g_next
      sitda_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .bit_in   (bit_out[i-1]),
        .digit_in (digit[i-1]),
        .bit_out  (bit_out[i]),
        .digit    (digit[i])
      );
    end
  end

  always_comb begin
    state_nxt         = state_r;
    mag_nxt           = mag_r;
    bitcnt_nxt        = bitcnt_r;
    left_nxt          = left_r;
    neg_nxt           = neg_r;
    ctrl              = '0;
    out_valid_nxt     = out_valid_r && out_stall;
    out_character_nxt = out_character_r;
    out_last_nxt      = out_last_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          neg_nxt    = value_u[VALUE_W-1];
          mag_nxt    = value_u[VALUE_W-1] ? (~value_u + VALUE_W'(1)) : value_u;
          bitcnt_nxt = '0;
          ctrl.clear = 1'b1;
          state_nxt  = S_CONV;
        end
      end
      S_CONV: begin
        ctrl.bcd_shift = 1'b1;
        mag_nxt        = {mag_r[VALUE_W-2:0], 1'b0};
        bitcnt_nxt     = bitcnt_r + CNT_W'(1);
        if (bitcnt_r == CNT_W'(VALUE_W - 1)) begin
          left_nxt  = LEFT_W'(NUM_CELLS);
          state_nxt = S_STRIP;
        end
      end
      S_STRIP: begin
        // Zero keeps its lowest digit, so at least one character is sent.
        if (top_zero && (left_r > LEFT_W'(1))) begin
          ctrl.digit_shift = 1'b1;
          left_nxt         = left_r - LEFT_W'(1);
        end else begin
          state_nxt = neg_r ? S_SIGN : S_EMIT;
        end
      end
      S_SIGN: begin
        if (slot_free) begin
          out_valid_nxt     = 1'b1;
          out_character_nxt = ASCII_MINUS;
          out_last_nxt      = 1'b0;
          state_nxt         = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt     = 1'b1;
          out_character_nxt = ASCII_ZERO | {{(CHAR_W - DIGIT_W){1'b0}}, digit[NUM_CELLS-1]};
          out_last_nxt      = (left_r == LEFT_W'(1));
          ctrl.digit_shift  = 1'b1;
          left_nxt          = left_r - LEFT_W'(1);
          if (left_r == LEFT_W'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r           <= mag_nxt;
    bitcnt_r        <= bitcnt_nxt;
    left_r          <= left_nxt;
    neg_r           <= neg_nxt;
    out_character_r <= out_character_nxt;
    out_last_r      <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_character_r;
  assign out_last      = out_last_r;

  a_accept_starts_conv: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_CONV))
    else $error("accepted value did not start the conversion");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_character == ASCII_MINUS)) |-> !out_last)
    else $error("minus sign marked as the final character");

  a_emit_has_digits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (left_r != '0))
    else $error("emitting with no digits left");

  a_strip_stops: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_STRIP) && !top_zero) |=> (state_r != S_STRIP))
    else $error("leading-zero removal passed a non-zero digit");

endmodule

`default_nettype wire

// ===== rtl/sitda_cell.sv =====
`default_nettype none

module sitda_cell
  import sitda_pkg::*;
(
  input  wire                clk,
  input  cell_ctrl_t         ctrl,
  input  wire                bit_in,
  input  wire  [DIGIT_W-1:0] digit_in,
  output logic               bit_out,
  output logic [DIGIT_W-1:0] digit
);

  logic [DIGIT_W-1:0] digit_r;
  logic [DIGIT_W-1:0] digit_nxt;
  logic [DIGIT_W-1:0] adj;

  // Add three before the shift so that the doubled digit carries at ten.
  assign adj     = (digit_r >= BCD_ADJ_MIN) ? (digit_r + BCD_ADJ) : digit_r;
  assign bit_out = adj[DIGIT_W-1];
  assign digit   = digit_r;

  always_comb begin
    digit_nxt = digit_r;
    if (ctrl.clear) begin
      digit_nxt = '0;
    end else if (ctrl.bcd_shift) begin
      digit_nxt = {adj[DIGIT_W-2:0], bit_in};
    end else if (ctrl.digit_shift) begin
      digit_nxt = digit_in;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

endmodule

`default_nettype wire
